// ----- rtl/encoder_click_classifier_top_macros.svh -----
// assertion macros used by the checker file
`ifndef ENCODER_CLICK_CLASSIFIER_TOP_MACROS_SVH
`define ENCODER_CLICK_CLASSIFIER_TOP_MACROS_SVH

// checked only outside reset
`define ECC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ECC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ecc_pkg.sv -----
`default_nettype none

package ecc_pkg;

   // timer width of the click and quiet counters
   localparam int TimerWidth = 16;
   localparam logic [32:0] TimerMaxWide = (33'd1 << TimerWidth) - 33'd1;

   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;
   localparam int WindowWidth   = 16;
   localparam int QuietWidth    = 16;
   localparam int PollsWidth    = 4;
   localparam int DeltaWidth    = 8;

   localparam logic [WindowWidth-1:0] ClickWindowReset = 16'd250;
   localparam logic [QuietWidth-1:0]  RotateQuietReset = 16'd50;
   localparam logic [PollsWidth-1:0]  StablePollsReset = 4'd2;
   localparam logic [PollsWidth-1:0]  StableCountMax   = 4'd15;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_CLICK_WINDOW = 2'd0,
      CSR_ROTATE_QUIET = 2'd1,
      CSR_STABLE_POLLS = 2'd2
   } csr_index_type;

   typedef logic [TimerWidth-1:0]        timer_type;
   typedef logic signed [DeltaWidth-1:0] delta_type;

   typedef struct packed {
      logic      rotate_out;
      delta_type delta_out;
      logic      click_once;
      logic      click_twice;
   } result_type;

   // saturate a 16-bit register value into the timer width
   function automatic timer_type sat_timer(input logic [15:0] v);
      logic [32:0] w;
      w = 33'(v);
      if (w > TimerMaxWide) begin
         return TimerMaxWide[TimerWidth-1:0];
      end
      return w[TimerWidth-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/encoder_click_classifier_top.sv -----
`default_nettype none

// channel   | direction | handshake             | payload
// req_      | in        | req_valid / req_stall | rotation, button-down, poll
// rsp_      | out       | rsp_valid / rsp_stall | rotation pass-through, clicks
// csr_      | in        | csr_valid / csr_ready | register index, write data
//
// one tick per cycle unless stalled; its state update is one short pass of
// counter and flag logic, and its result enters the output or skid register
// reset (synchronous, active high) loads reset values and empties both buffers
// a stalled result sits in the output register; one further tick is taken into
// a skid register, and req_stall rises only while the skid register is full
// csr_ready is always high; each write lands directly in its register

module encoder_click_classifier_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_rotate_event,
   input  wire ecc_pkg::delta_type                req_rotate_delta,
   input  wire logic                              req_button_down_event,
   input  wire logic                              req_poll_valid,
   input  wire logic                              req_switch_level,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_rotate_out,
   output ecc_pkg::delta_type                     rsp_delta_out,
   output logic                                   rsp_click_once,
   output logic                                   rsp_click_twice,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ecc_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [ecc_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import ecc_pkg::*;

   // configuration registers
   logic [WindowWidth-1:0] click_window_ff;
   logic [QuietWidth-1:0]  rotate_quiet_ff;
   logic [PollsWidth-1:0]  stable_polls_ff;

   // tick state
   logic                  click_pending_ff, click_pending_in;
   timer_type             click_timer_ff, click_timer_in;
   logic                  last_level_ff, last_level_in;
   logic [PollsWidth-1:0] stable_count_ff, stable_count_in;
   logic                  press_latched_ff, press_latched_in;
   timer_type             quiet_timer_ff, quiet_timer_in;

   // output register and skid register
   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   result_type skid_ff, skid_in;
   logic       skid_valid_ff, skid_valid_in;

   result_type result;
   logic       accept;
   logic       take;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~req_stall;
   assign take      = out_valid_ff & ~rsp_stall;

   assign rsp_valid       = out_valid_ff;
   assign rsp_rotate_out  = out_ff.rotate_out;
   assign rsp_delta_out   = out_ff.delta_out;
   assign rsp_click_once  = out_ff.click_once;
   assign rsp_click_twice = out_ff.click_twice;

   // per-tick update: click timer, quiet window, rotation, button event, poll
   always_comb begin
      logic                  active;
      logic [PollsWidth-1:0] need;
      logic                  single;
      logic                  dbl;

      click_pending_in = click_pending_ff;
      click_timer_in   = click_timer_ff;
      last_level_in    = last_level_ff;
      stable_count_in  = stable_count_ff;
      press_latched_in = press_latched_ff;
      quiet_timer_in   = quiet_timer_ff;
      single           = 1'b0;
      dbl              = 1'b0;

      // click window expiry comes first in the tick
      if (click_pending_in) begin
         if (click_timer_in <= TimerWidth'(1)) begin
            click_pending_in = 1'b0;
            click_timer_in   = '0;
            single           = 1'b1;
         end else begin
            click_timer_in = click_timer_in - TimerWidth'(1);
         end
      end

      if (quiet_timer_in != '0) begin
         quiet_timer_in = quiet_timer_in - TimerWidth'(1);
      end

      // rotation restarts the quiet window and drops a pending click
      if (req_rotate_event) begin
         quiet_timer_in   = sat_timer(rotate_quiet_ff);
         click_pending_in = 1'b0;
         click_timer_in   = '0;
      end

      // edge-detected press
      if (req_button_down_event) begin
         if (click_pending_in) begin
            click_pending_in = 1'b0;
            click_timer_in   = '0;
            dbl              = 1'b1;
         end else begin
            click_pending_in = 1'b1;
            click_timer_in   = sat_timer(click_window_ff);
         end
      end

      // debounced poll
      active = (quiet_timer_in != '0);
      need   = (stable_polls_ff == '0) ? PollsWidth'(1) : stable_polls_ff;
      if (req_poll_valid) begin
         if (req_switch_level) begin
            press_latched_in = 1'b0;
         end
         if (active) begin
            stable_count_in = '0;
         end
         if ((req_switch_level == last_level_in) && !active && !press_latched_in) begin
            if (!req_switch_level) begin
               if (stable_count_in < StableCountMax) begin
                  stable_count_in = stable_count_in + PollsWidth'(1);
               end
               if (stable_count_in >= need) begin
                  stable_count_in  = '0;
                  press_latched_in = 1'b1;
                  if (click_pending_in) begin
                     click_pending_in = 1'b0;
                     click_timer_in   = '0;
                     dbl              = 1'b1;
                  end else begin
                     click_pending_in = 1'b1;
                     click_timer_in   = sat_timer(click_window_ff);
                  end
               end
            end
         end else begin
            last_level_in   = req_switch_level;
            stable_count_in = '0;
         end
      end

      result.rotate_out  = req_rotate_event;
      result.delta_out   = req_rotate_event ? req_rotate_delta : '0;
      result.click_once  = single;
      result.click_twice = dbl;
   end

   // output and skid buffering
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = skid_valid_ff | accept | (out_valid_ff & ~take);
      skid_valid_in = skid_valid_ff ? ~take : (accept & out_valid_ff & ~take);
      if (take && skid_valid_ff) begin
         out_in = skid_ff;
      end else if (accept && (!out_valid_ff || take)) begin
         out_in = result;
      end else if (accept) begin
         skid_in = result;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
         click_window_ff  <= ClickWindowReset;
         rotate_quiet_ff  <= RotateQuietReset;
         stable_polls_ff  <= StablePollsReset;
         click_pending_ff <= 1'b0;
         click_timer_ff   <= '0;
         last_level_ff    <= 1'b1;
         stable_count_ff  <= '0;
         press_latched_ff <= 1'b0;
         quiet_timer_ff   <= '0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (accept) begin
            click_pending_ff <= click_pending_in;
            click_timer_ff   <= click_timer_in;
            last_level_ff    <= last_level_in;
            stable_count_ff  <= stable_count_in;
            press_latched_ff <= press_latched_in;
            quiet_timer_ff   <= quiet_timer_in;
         end
         // register writes; indexes off the list are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CLICK_WINDOW: click_window_ff <= csr_wdata[WindowWidth-1:0];
               CSR_ROTATE_QUIET: rotate_quiet_ff <= csr_wdata[QuietWidth-1:0];
               CSR_STABLE_POLLS: stable_polls_ff <= csr_wdata[PollsWidth-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/ecc_checker.sv -----
`default_nettype none

`include "encoder_click_classifier_top_macros.svh"

module ecc_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic               rsp_rotate_out,
   input wire ecc_pkg::delta_type rsp_delta_out,
   input wire logic               csr_valid,
   input wire logic               csr_ready
);

   // buffers come out of reset empty, so nothing is shown and input is open
   `ECC_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid && !req_stall, "buffers not empty after reset")

   // delta is only forwarded with a rotation
   `ECC_ASSERT(a_delta_zero, clock, reset, rsp_valid && !rsp_rotate_out |-> rsp_delta_out == 0, "delta without rotation")

   // a stalled result is not dropped
   `ECC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "stalled result dropped")

   // registers never hold off a write
   `ECC_ASSERT(a_csr_ready, clock, reset, csr_valid |-> csr_ready, "register write refused")

endmodule

bind encoder_click_classifier_top ecc_checker u_ecc_checker (.*);

`default_nettype wire
